/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge, with reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define UVS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define UVS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* design/uvs_pkg.sv */
// ----------------------------------------------------------------------------
// UV sphere generator package
// Register indexes, point kinds and CORDIC constants.
// ----------------------------------------------------------------------------
package uvs_pkg;

	localparam logic [1:0] REG_RADIUS   = 2'd0;
	localparam logic [1:0] REG_SEGMENTS = 2'd1;
	localparam logic [1:0] REG_RINGS    = 2'd2;

	localparam logic [1:0] KIND_QUAD    = 2'd0;
	localparam logic [1:0] KIND_VERTEX  = 2'd1;
	localparam logic [1:0] KIND_OUTSIDE = 2'd2;

	localparam logic [7:0] MIN_SEGMENTS = 8'd3;
	localparam logic [7:0] MIN_RINGS    = 8'd2;

	localparam logic [15:0] RADIUS_RST   = 16'd256;
	localparam logic [7:0]  SEGMENTS_RST = 8'd16;
	localparam logic [7:0]  RINGS_RST    = 8'd16;

	localparam int CORDIC_STEPS = 24;
	localparam logic signed [31:0] CORDIC_GAIN_INV = 32'sh26DD3B6A;
	localparam logic [31:0] HALF_PI_Q30 = 32'h6487ED51;

	// atan(2^-i) in Q30
	function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
		logic signed [31:0] r;
		case (idx)
			5'd0: r = 32'sh3243F6A8;
			5'd1: r = 32'sh1DAC6705;
			5'd2: r = 32'sh0FADBAFC;
			5'd3: r = 32'sh07F56EA6;
			5'd4: r = 32'sh03FEAB76;
			5'd5: r = 32'sh01FFD55B;
			5'd6: r = 32'sh00FFFAAA;
			5'd7: r = 32'sh007FFF55;
			5'd8: r = 32'sh003FFFEA;
			5'd9: r = 32'sh001FFFFD;
			5'd10: r = 32'sh000FFFFF;
			5'd11: r = 32'sh0007FFFF;
			5'd12: r = 32'sh0003FFFF;
			5'd13: r = 32'sh0001FFFF;
			5'd14: r = 32'sh0000FFFF;
			5'd15: r = 32'sh00007FFF;
			5'd16: r = 32'sh00003FFF;
			5'd17: r = 32'sh00001FFF;
			5'd18: r = 32'sh00000FFF;
			5'd19: r = 32'sh000007FF;
			5'd20: r = 32'sh000003FF;
			5'd21: r = 32'sh000001FF;
			5'd22: r = 32'sh000000FF;
			5'd23: r = 32'sh0000007F;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage

/* design/uvs_divider.sv */
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division by an 8-bit divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module uvs_divider import uvs_pkg::*; #(
	parameter int NUM_W = 24
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [7:0]       den,
	output logic [NUM_W-1:0] quo
);

	// {remainder, dividend bits still to go / quotient bits so far}
	logic [NUM_W+7:0] work_s [NUM_W];

	function automatic logic [NUM_W+7:0] div_step(input logic [NUM_W+7:0] w,
			input logic [7:0] d);
		logic [NUM_W+8:0] t;
		logic [8:0]       top;
		t   = {w, 1'b0};
		top = t[NUM_W+8:NUM_W];
		if (top >= {1'b0, d}) begin
			top  = top - {1'b0, d};
			t[0] = 1'b1;
		end
		return {top[7:0], t[NUM_W-1:0]};
	endfunction

	always_ff @(posedge clk) begin
		work_s[0] <= div_step({8'd0, num}, den);
	end

	for (genvar i = 1; i < NUM_W; i++) begin : g_stage
		always_ff @(posedge clk) begin
			work_s[i] <= div_step(work_s[i-1], den);
		end
	end

	assign quo = work_s[NUM_W-1][NUM_W-1:0];

endmodule

/* design/uvs_cordic.sv */
// ----------------------------------------------------------------------------
// Pipelined sine/cosine
// Quadrant split, radian scaling, 24 rotation steps and quadrant fold-back.
// ----------------------------------------------------------------------------
module uvs_cordic import uvs_pkg::*; #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                    clk,
	input  logic [ANGLE_BITS-1:0]   angle,
	output logic signed [31:0]      cos_val,
	output logic signed [31:0]      sin_val
);

	localparam int RW = ANGLE_BITS - 2;
	localparam int PW = RW + 32;

	logic [PW-1:0]      prod;
	logic [1:0]         quad_s [CORDIC_STEPS+1];
	logic signed [31:0] x_s    [CORDIC_STEPS+1];
	logic signed [31:0] y_s    [CORDIC_STEPS+1];
	logic signed [31:0] z_s    [CORDIC_STEPS+1];

	assign prod = PW'(angle[RW-1:0]) * PW'(HALF_PI_Q30);

	always_ff @(posedge clk) begin
		quad_s[0] <= angle[ANGLE_BITS-1:RW];
		x_s[0]    <= CORDIC_GAIN_INV;
		y_s[0]    <= 32'sd0;
		z_s[0]    <= signed'(32'(prod >> RW));
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			quad_s[i+1] <= quad_s[i];
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_q30(5'(i));
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_q30(5'(i));
			end
		end
	end

	always_ff @(posedge clk) begin
		case (quad_s[CORDIC_STEPS])
			2'd0: begin
				cos_val <= x_s[CORDIC_STEPS];
				sin_val <= y_s[CORDIC_STEPS];
			end
			2'd1: begin
				cos_val <= -y_s[CORDIC_STEPS];
				sin_val <= x_s[CORDIC_STEPS];
			end
			2'd2: begin
				cos_val <= -x_s[CORDIC_STEPS];
				sin_val <= -y_s[CORDIC_STEPS];
			end
			default: begin
				cos_val <= y_s[CORDIC_STEPS];
				sin_val <= -x_s[CORDIC_STEPS];
			end
		endcase
	end

endmodule

/* design/uv_sphere_vertex_generator_core.sv */
// Throughput: one grid point per cycle; busy stays low, nothing ever stalls.
// The pipeline holds the bit-serial dividers (one bit per stage), then the
// 24-step CORDIC with its load and fold stages and four multiply/round stages.
// Reset clears the valid line and loads the registers with radius 256, 16 segments, 16 rings.
// Results cannot be held off by the receiver; each shows for one cycle only.
// ----------------------------------------------------------------------------
// UV sphere vertex generator core
// Per grid point: position, uv, tangent and quad corner indices, fully pipelined.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uv_sphere_vertex_generator_core import uvs_pkg::*; #(
	parameter int MAX_DIVISIONS = 255,
	parameter int ANGLE_BITS    = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command side
	input  logic                  start,
	output logic                  busy,
	input  logic [7:0]            row_index,
	input  logic [7:0]            column_index,
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	// results
	output logic                  done,
	output logic signed [16:0]    pos_x,
	output logic signed [16:0]    pos_y,
	output logic signed [16:0]    pos_z,
	output logic [16:0]           tex_u,
	output logic [16:0]           tex_v,
	output logic signed [15:0]    tangent_x,
	output logic signed [15:0]    tangent_z,
	output logic [15:0]           corner_a,
	output logic [15:0]           corner_b,
	output logic [15:0]           corner_c,
	output logic [15:0]           corner_d,
	output logic [1:0]            point_kind
);

	// divider width covers col << max(16, ANGLE_BITS) plus the rounding half
	localparam int DW       = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 8;
	localparam int SIDE_LEN = DW + 29;   // accept -> last stage before output
	localparam int TEX_LEN  = 29;        // divider out -> last stage before output
	localparam int LAT      = DW + 30;   // accept edge -> edge that takes the result

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] ca;
		logic [15:0] cb;
		logic [15:0] cc;
		logic [15:0] cd;
	} side_t;

	typedef struct packed {
		logic [16:0] u;
		logic [16:0] v;
	} tex_t;

	// ---- configuration registers ----
	// The user is to keep them written only while idle, so every stage reads them live; the block does not enforce it.
	logic [15:0] radius_q;
	logic [7:0]  seg_q;
	logic [7:0]  ring_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			seg_q    <= SEGMENTS_RST;
			ring_q   <= RINGS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RADIUS:   radius_q <= cfg_data;
				REG_SEGMENTS: seg_q    <= cfg_data[7:0];
				REG_RINGS:    ring_q   <= cfg_data[7:0];
				default: ;   // unknown index: write dropped
			endcase
		end
	end

	// effective divisions: capped at MAX_DIVISIONS, floored at 3 / 2
	logic [7:0] seg_cap, ring_cap, seg_eff, ring_eff;

	always_comb begin
		seg_cap  = (32'(seg_q) > MAX_DIVISIONS) ? 8'(MAX_DIVISIONS) : seg_q;
		ring_cap = (32'(ring_q) > MAX_DIVISIONS) ? 8'(MAX_DIVISIONS) : ring_q;
		seg_eff  = (seg_cap < MIN_SEGMENTS) ? MIN_SEGMENTS : seg_cap;
		ring_eff = (ring_cap < MIN_RINGS) ? MIN_RINGS : ring_cap;
	end

	logic accept;
	assign accept = start && !busy;

	// ---- classification and corner indices at entry ----
	side_t       side_in;
	logic [8:0]  width9;
	logic [16:0] row_base;

	always_comb begin
		width9   = {1'b0, seg_eff} + 9'd1;
		row_base = 17'(row_index) * 17'(width9);
		side_in  = '0;
		if (row_index > ring_eff || column_index > seg_eff) begin
			side_in.kind = KIND_OUTSIDE;
		end else if (row_index == ring_eff || column_index == seg_eff) begin
			side_in.kind = KIND_VERTEX;
		end else begin
			side_in.kind = KIND_QUAD;
			side_in.ca   = 16'(row_base + 17'(column_index));
			side_in.cb   = 16'(row_base + 17'(column_index) + 17'd1);
			side_in.cd   = 16'(row_base + 17'(width9) + 17'(column_index));
			side_in.cc   = 16'(row_base + 17'(width9) + 17'(column_index) + 17'd1);
		end
	end

	// side line: valid bits reset, payload does not
	logic  vld_s  [SIDE_LEN];
	side_t side_s [SIDE_LEN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SIDE_LEN; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[0] <= accept;
			for (int k = 1; k < SIDE_LEN; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= side_in;
		for (int k = 1; k < SIDE_LEN; k++) side_s[k] <= side_s[k-1];
	end

	// ---- rounded divisions: (n + d/2) / d ----
	logic [DW-1:0] num_u, num_v, num_phi, num_th;
	logic [DW-1:0] quo_u, quo_v, quo_phi, quo_th;

	always_comb begin
		num_u   = (DW'(column_index) << 16) + DW'(seg_eff[7:1]);
		num_phi = (DW'(column_index) << ANGLE_BITS) + DW'(seg_eff[7:1]);
		num_v   = (DW'(row_index) << 16) + DW'(ring_eff[7:1]);
		num_th  = (DW'(row_index) << (ANGLE_BITS - 1)) + DW'(ring_eff[7:1]);
	end

	uvs_divider #(.NUM_W(DW)) u_div_u (
		.clk(clk), .num(num_u), .den(seg_eff), .quo(quo_u)
	);
	uvs_divider #(.NUM_W(DW)) u_div_phi (
		.clk(clk), .num(num_phi), .den(seg_eff), .quo(quo_phi)
	);
	uvs_divider #(.NUM_W(DW)) u_div_v (
		.clk(clk), .num(num_v), .den(ring_eff), .quo(quo_v)
	);
	uvs_divider #(.NUM_W(DW)) u_div_th (
		.clk(clk), .num(num_th), .den(ring_eff), .quo(quo_th)
	);

	// texture coords wait for the trig and multiply stages
	tex_t tex_s [TEX_LEN];

	always_ff @(posedge clk) begin
		tex_s[0] <= '{u: quo_u[16:0], v: quo_v[16:0]};
		for (int k = 1; k < TEX_LEN; k++) tex_s[k] <= tex_s[k-1];
	end

	// ---- sine / cosine ----
	// phi wraps mod one turn by truncation; theta stays within half a turn for on-grid rows
	logic signed [31:0] cos_phi, sin_phi, cos_th, sin_th;

	uvs_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_phi (
		.clk(clk), .angle(quo_phi[ANGLE_BITS-1:0]),
		.cos_val(cos_phi), .sin_val(sin_phi)
	);
	uvs_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_th (
		.clk(clk), .angle(quo_th[ANGLE_BITS-1:0]),
		.cos_val(cos_th), .sin_val(sin_th)
	);

	// ---- rounding / clamping helpers ----
	function automatic logic signed [63:0] round30(input logic signed [63:0] v);
		return (v + 64'sd536870912) >>> 30;
	endfunction

	function automatic logic signed [16:0] clamp_pos(input logic signed [63:0] v);
		logic signed [16:0] r;
		if (v > 64'sd65535) r = 17'sd65535;
		else if (v < -64'sd65535) r = -17'sd65535;
		else r = v[16:0];
		return r;
	endfunction

	function automatic logic signed [15:0] clamp_tan(input logic signed [63:0] v);
		logic signed [15:0] r;
		if (v > 64'sd16384) r = 16'sd16384;
		else if (v < -64'sd16384) r = -16'sd16384;
		else r = v[15:0];
		return r;
	endfunction

	logic signed [16:0] radius_s;
	assign radius_s = signed'({1'b0, radius_q});

	// ---- stage 1: trig products, tangent ----
	logic signed [63:0] prod_x_s1, prod_z_s1, prod_y_s1;
	logic signed [15:0] tan_x_s1, tan_z_s1;

	always_ff @(posedge clk) begin
		prod_x_s1 <= sin_th * cos_phi;
		prod_z_s1 <= sin_th * sin_phi;
		prod_y_s1 <= radius_s * cos_th;
		tan_x_s1  <= clamp_tan(-((64'(sin_phi) + 64'sd32768) >>> 16));
		tan_z_s1  <= clamp_tan((64'(cos_phi) + 64'sd32768) >>> 16);
	end

	// ---- stage 2: unit-sphere point, final y ----
	logic signed [33:0] p_x_s2, p_z_s2;
	logic signed [16:0] pos_y_s2;
	logic signed [15:0] tan_x_s2, tan_z_s2;

	always_ff @(posedge clk) begin
		p_x_s2   <= 34'(round30(prod_x_s1));
		p_z_s2   <= 34'(round30(prod_z_s1));
		pos_y_s2 <= clamp_pos(round30(prod_y_s1));
		tan_x_s2 <= tan_x_s1;
		tan_z_s2 <= tan_z_s1;
	end

	// ---- stage 3: scale by radius ----
	logic signed [63:0] prod_x_s3, prod_z_s3;
	logic signed [16:0] pos_y_s3;
	logic signed [15:0] tan_x_s3, tan_z_s3;

	always_ff @(posedge clk) begin
		prod_x_s3 <= radius_s * p_x_s2;
		prod_z_s3 <= radius_s * p_z_s2;
		pos_y_s3  <= pos_y_s2;
		tan_x_s3  <= tan_x_s2;
		tan_z_s3  <= tan_z_s2;
	end

	// ---- output register ----
	side_t sd_last;
	tex_t  tx_last;
	logic  outside;

	assign sd_last = side_s[SIDE_LEN-1];
	assign tx_last = tex_s[TEX_LEN-1];
	assign outside = (sd_last.kind == KIND_OUTSIDE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s[SIDE_LEN-1];
		end
	end

	// off-grid points report zeros everywhere but the kind
	always_ff @(posedge clk) begin
		pos_x      <= outside ? 17'sd0 : clamp_pos(round30(prod_x_s3));
		pos_z      <= outside ? 17'sd0 : clamp_pos(round30(prod_z_s3));
		pos_y      <= outside ? 17'sd0 : pos_y_s3;
		tex_u      <= outside ? 17'd0 : tx_last.u;
		tex_v      <= outside ? 17'd0 : tx_last.v;
		tangent_x  <= outside ? 16'sd0 : tan_x_s3;
		tangent_z  <= outside ? 16'sd0 : tan_z_s3;
		corner_a   <= sd_last.ca;
		corner_b   <= sd_last.cb;
		corner_c   <= sd_last.cc;
		corner_d   <= sd_last.cd;
		point_kind <= sd_last.kind;
	end

	// ---- checks ----
	`UVS_ASSERT_IMP(a_done_has_cmd, clk, arst_n, done, $past(start, LAT),
		"result without a transaction LAT cycles earlier")
	`UVS_ASSERT_IMP(a_outside_zero, clk, arst_n, done && point_kind == KIND_OUTSIDE,
		pos_x == 0 && pos_y == 0 && pos_z == 0 && tex_u == 0 && tex_v == 0 &&
		tangent_x == 0 && tangent_z == 0, "off-grid result carries data")
	`UVS_ASSERT_IMP(a_no_quad_corners, clk, arst_n, done && point_kind != KIND_QUAD,
		corner_a == 0 && corner_b == 0 && corner_c == 0 && corner_d == 0,
		"corners on a point without a quad")
	`UVS_ASSERT_IMP(a_quad_adjacent, clk, arst_n, done && point_kind == KIND_QUAD,
		corner_b == corner_a + 16'd1 && corner_c == corner_d + 16'd1,
		"quad corners not adjacent")

endmodule

/* dv/uv_sphere_vertex_generator_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator core testbench
// Streams grid points under several radius/segment/ring settings and checks
// every vertex against a bit-exact software copy of the fixed-point math.
// ----------------------------------------------------------------------------

module uv_sphere_vertex_generator_core_tb;
	import uvs_pkg::*;

	// index 3 maps to no register; writes to it must be dropped
	localparam logic [1:0] REG_UNMAPPED = 2'd3;
	localparam int LATENCY_SLACK = 80;

	typedef struct packed {
		logic signed [16:0] px;
		logic signed [16:0] py;
		logic signed [16:0] pz;
		logic [16:0]        u;
		logic [16:0]        v;
		logic signed [15:0] tx;
		logic signed [15:0] tz;
		logic [15:0]        ca;
		logic [15:0]        cb;
		logic [15:0]        cc;
		logic [15:0]        cd;
		logic [1:0]         kind;
	} vertex_t;

	// Expected-vertex store plus the shadow copy of the registers
	class vertex_scoreboard;
		vertex_t     pending_q[$];
		int          errors;
		int          checked;
		int          kind_seen[3];
		logic [15:0] radius;
		logic [7:0]  segments;
		logic [7:0]  rings;
		longint      atan_tab[24];

		function new();
			atan_tab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
				64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
				64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
				64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
				64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
				64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
			radius = RADIUS_RST;
			segments = SEGMENTS_RST;
			rings = RINGS_RST;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] data);
			case (idx)
				REG_RADIUS:   radius = data;
				REG_SEGMENTS: segments = data[7:0];
				REG_RINGS:    rings = data[7:0];
				default:      ;
			endcase
		endfunction

		function longint rshift_round(longint val, int sh);
			return (val + (64'sd1 <<< (sh - 1))) >>> sh;
		endfunction

		function longint clip(longint val, longint lim);
			if (val > lim) return lim;
			if (val < -lim) return -lim;
			return val;
		endfunction

		// turn-based angle (16 bits per turn) -> cos, sin in Q30
		function void angle_cos_sin(longint unsigned ang, output longint cv, output longint sv);
			longint unsigned quad;
			longint unsigned rest;
			longint x, y, z, nx;
			ang = ang & 64'hFFFF;
			quad = ang >> 14;
			rest = ang & 64'h3FFF;
			z = longint'((rest * 64'h6487ED51) >> 14);
			x = 64'h26DD3B6A;
			y = 0;
			for (int i = 0; i < 24; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z = z - atan_tab[i];
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z = z + atan_tab[i];
				end
				x = nx;
			end
			case (quad)
				0: begin cv = x; sv = y; end
				1: begin cv = -y; sv = x; end
				2: begin cv = -x; sv = -y; end
				default: begin cv = y; sv = -x; end
			endcase
		endfunction

		function void note_point(logic [7:0] row, logic [7:0] col);
			vertex_t e;
			longint unsigned s, r, w, phi, theta;
			longint cp, sp, ct, st, rad;
			s = segments;
			r = rings;
			if (s < MIN_SEGMENTS) s = MIN_SEGMENTS;
			if (r < MIN_RINGS) r = MIN_RINGS;
			e = '0;
			if (row > r || col > s) begin
				e.kind = KIND_OUTSIDE;
			end else begin
				e.u = 17'(((longint'(col) << 16) + s / 2) / s);
				e.v = 17'(((longint'(row) << 16) + r / 2) / r);
				phi = ((longint'(col) << 16) + s / 2) / s;
				theta = ((longint'(row) << 15) + r / 2) / r;
				angle_cos_sin(phi, cp, sp);
				angle_cos_sin(theta, ct, st);
				rad = radius;
				e.px = 17'(clip(rshift_round(rad * rshift_round(st * cp, 30), 30), 65535));
				e.py = 17'(clip(rshift_round(rad * ct, 30), 65535));
				e.pz = 17'(clip(rshift_round(rad * rshift_round(st * sp, 30), 30), 65535));
				e.tx = 16'(clip(-rshift_round(sp, 16), 16384));
				e.tz = 16'(clip(rshift_round(cp, 16), 16384));
				if (row < r && col < s) begin
					w = s + 1;
					e.ca = 16'(row * w + col);
					e.cb = 16'(row * w + col + 1);
					e.cc = 16'((row + 1) * w + col + 1);
					e.cd = 16'((row + 1) * w + col);
					e.kind = KIND_QUAD;
				end else begin
					e.kind = KIND_VERTEX;
				end
			end
			pending_q = {pending_q, e};
		endfunction

		function void field(string name, logic [16:0] exp_v, logic [16:0] act_v);
			if (exp_v !== act_v) begin
				errors++;
				$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
			end
		endfunction

		function void check_vertex(vertex_t got);
			vertex_t e;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected result, kind %0d", $time, got.kind);
				return;
			end
			e = pending_q.pop_front();
			checked++;
			if (e.kind < 3) kind_seen[e.kind]++;
			field("pos_x", 17'(e.px), 17'(got.px));
			field("pos_y", 17'(e.py), 17'(got.py));
			field("pos_z", 17'(e.pz), 17'(got.pz));
			field("tex_u", e.u, got.u);
			field("tex_v", e.v, got.v);
			field("tangent_x", 17'(e.tx), 17'(got.tx));
			field("tangent_z", 17'(e.tz), 17'(got.tz));
			field("corner_a", 17'(e.ca), 17'(got.ca));
			field("corner_b", 17'(e.cb), 17'(got.cb));
			field("corner_c", 17'(e.cc), 17'(got.cc));
			field("corner_d", 17'(e.cd), 17'(got.cd));
			field("point_kind", 17'(e.kind), 17'(got.kind));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [7:0] row_index = '0;
	logic [7:0] column_index = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic done;
	logic signed [16:0] pos_x, pos_y, pos_z;
	logic [16:0] tex_u, tex_v;
	logic signed [15:0] tangent_x, tangent_z;
	logic [15:0] corner_a, corner_b, corner_c, corner_d;
	logic [1:0] point_kind;

	vertex_scoreboard sb = new();
	int idle_pct;
	int accepted;

	always #2 clk = ~clk;

	uv_sphere_vertex_generator_core dut (.*);

	// Monitor: note each accepted transaction, check each result strobe.
	// A result never appears in the edge that accepts its point, so the order inside the edge is moot.
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			sb.note_point(row_index, column_index);
			accepted++;
		end
		if (arst_n && done)
			sb.check_vertex('{pos_x, pos_y, pos_z, tex_u, tex_v, tangent_x, tangent_z,
				corner_a, corner_b, corner_c, corner_d, point_kind});
	end

	// Present one grid point, hold until taken, then maybe leave a gap.
	// start stays high across back-to-back points.
	task automatic send_point(input logic [7:0] row, input logic [7:0] col);
		start <= 1'b1;
		row_index <= row;
		column_index <= col;
		do @(posedge clk); while (busy);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Wait for every outstanding vertex, then the pipeline's tail
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (LATENCY_SLACK) @(posedge clk);
	endtask

	// Register write; only called with the pipeline empty.
	// cfg_valid drops after each write, which keeps back-to-back calls apart.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly on-grid points (including the last row/column and one past),
	// some fully random ones to hit the outside-grid path and all input bits
	task automatic random_points(input int count);
		int s, r;
		s = (sb.segments < MIN_SEGMENTS) ? MIN_SEGMENTS : sb.segments;
		r = (sb.rings < MIN_RINGS) ? MIN_RINGS : sb.rings;
		repeat (count) begin
			if ($urandom_range(99) < 75)
				send_point(8'($urandom_range(r + 1 > 255 ? 255 : r + 1)),
					8'($urandom_range(s + 1 > 255 ? 255 : s + 1)));
			else
				send_point(8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		#2_000_000;
		$display("uv_sphere_vertex_generator_core_tb: done, errors");
		$finish;
	end

	initial begin
		logic [15:0] radii[6];
		logic [7:0]  segs[6];
		logic [7:0]  rngs[6];
		int          idle_by_phase[4];
		radii = '{16'd256, 16'hFFFF, 16'd0, 16'h8000, 16'd1000, 16'h1234};
		segs  = '{8'd16, 8'd255, 8'd0, 8'd1, 8'd3, 8'd200};
		rngs  = '{8'd16, 8'd255, 8'd0, 8'd1, 8'd2, 8'd97};
		idle_by_phase = '{0, 67, 0, 27};
		idle_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings: poles, equator, seam, grid edges, outside
		send_point(8'd0, 8'd0);
		send_point(8'd16, 8'd0);
		send_point(8'd8, 8'd4);
		send_point(8'd8, 8'd8);
		send_point(8'd8, 8'd12);
		send_point(8'd15, 8'd15);
		send_point(8'd16, 8'd16);
		send_point(8'd3, 8'd16);
		send_point(8'd17, 8'd0);
		send_point(8'd0, 8'd17);
		send_point(8'd255, 8'd255);
		send_point(8'hAA, 8'h55);
		send_point(8'h55, 8'hAA);
		drain();

		// unmapped register index must leave the settings alone
		write_reg(REG_UNMAPPED, 16'h0005);
		send_point(8'd16, 8'd15);
		drain();

		// largest grid: highest corner indices at the bottom row
		write_reg(REG_RADIUS, 16'hFFFF);
		write_reg(REG_SEGMENTS, 16'd255);
		write_reg(REG_RINGS, 16'd255);
		send_point(8'd254, 8'd254);
		send_point(8'd255, 8'd255);
		send_point(8'd128, 8'd0);
		send_point(8'd128, 8'd64);
		send_point(8'd0, 8'd255);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_RADIUS, radii[ph]);
			write_reg(REG_SEGMENTS, {8'd0, segs[ph]});
			write_reg(REG_RINGS, {8'd0, rngs[ph]});
			for (int ip = 0; ip < 4; ip++) begin
				idle_pct = idle_by_phase[ip];
				random_points(20);
			end
			drain();
		end

		idle_pct = 0;
		drain();
		$display("covered %0d points over 6 register settings", accepted);
		$display("  %0d quads, %0d edge vertices, %0d outside",
			sb.kind_seen[KIND_QUAD], sb.kind_seen[KIND_VERTEX], sb.kind_seen[KIND_OUTSIDE]);
		if (sb.errors == 0)
			$display("uv_sphere_vertex_generator_core_tb: done, clean");
		else
			$display("uv_sphere_vertex_generator_core_tb: done, errors");
		$finish;
	end

endmodule
